FILE: hw/rtl/gfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfp_pkg
// Shared types and constants for the gzip member framing parser.
// ----------------------------------------------------------------------------
package gfp_pkg;

  localparam logic [7:0] MAGIC0       = 8'h1f;
  localparam logic [7:0] MAGIC1       = 8'h8b;
  localparam logic [7:0] CM_DEFLATE   = 8'h08;
  localparam logic [7:0] FLG_RESERVED = 8'he0;

  // flag bit positions
  localparam int FLG_FHCRC    = 1;
  localparam int FLG_FEXTRA   = 2;
  localparam int FLG_FNAME    = 3;
  localparam int FLG_FCOMMENT = 4;

  localparam int HDR_FIXED_LEN = 10;
  localparam logic [15:0] FIXED_SKIP = 16'(HDR_FIXED_LEN - 4);
  localparam logic [15:0] HCRC_LEN   = 16'd2;

  localparam int TRAILER_LEN = 8;
  localparam int DLY_IDX_W   = $clog2(TRAILER_LEN);
  localparam int FILL_W      = DLY_IDX_W + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int OUT_CNT_W = 24;

  // field stages for picking the next optional header field
  localparam logic [2:0] STG_EXTRA   = 3'd0;
  localparam logic [2:0] STG_NAME    = 3'd1;
  localparam logic [2:0] STG_COMMENT = 3'd2;
  localparam logic [2:0] STG_HCRC    = 3'd3;
  localparam logic [2:0] STG_PAYLOAD = 3'd4;

  typedef enum logic [3:0] {
    PH_MAGIC0  = 4'd0,
    PH_MAGIC1  = 4'd1,
    PH_METHOD  = 4'd2,
    PH_FLAGS   = 4'd3,
    PH_FIXED   = 4'd4,
    PH_XLEN0   = 4'd5,
    PH_XLEN1   = 4'd6,
    PH_XDATA   = 4'd7,
    PH_NAME    = 4'd8,
    PH_COMMENT = 4'd9,
    PH_HCRC    = 4'd10,
    PH_PAYLOAD = 4'd11
  } phase_t;

  // one word handed from the delay line to the parser
  typedef struct packed {
    logic        has_byte;
    logic [7:0]  pbyte;
    logic        last;
    logic        full;
    logic [31:0] crc;
    logic [31:0] size;
  } gfp_entry_t;

  function automatic phase_t next_field(logic [2:0] stage, logic [7:0] flags);
    phase_t ph;
    if (stage < STG_NAME && flags[FLG_FEXTRA]) begin
      ph = PH_XLEN0;
    end else if (stage < STG_COMMENT && flags[FLG_FNAME]) begin
      ph = PH_NAME;
    end else if (stage < STG_HCRC && flags[FLG_FCOMMENT]) begin
      ph = PH_COMMENT;
    end else if (stage < STG_PAYLOAD && flags[FLG_FHCRC]) begin
      ph = PH_HCRC;
    end else begin
      ph = PH_PAYLOAD;
    end
    return ph;
  endfunction

endpackage

FILE: hw/rtl/gfp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfp_front
// Trailer delay line: holds the newest eight bytes, releases the oldest one
// to the parser and snapshots the trailer on the final byte.
// ----------------------------------------------------------------------------
module gfp_front
  import gfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] byte_in,
  input  logic       is_last,
  output gfp_entry_t entry
);

  logic [7:0]        dly_r   [TRAILER_LEN];
  logic [7:0]        dly_nxt [TRAILER_LEN];
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;

  always_comb begin
    dly_nxt        = dly_r;
    fill_nxt       = fill_r;
    entry.has_byte = fill_r[DLY_IDX_W];
    entry.pbyte    = dly_r[0];
    entry.last     = is_last;
    if (fill_r[DLY_IDX_W]) begin
      for (int i = 0; i < TRAILER_LEN - 1; i++) begin
        dly_nxt[i] = dly_r[i+1];
      end
      dly_nxt[TRAILER_LEN-1] = byte_in;
    end else begin
      dly_nxt[fill_r[DLY_IDX_W-1:0]] = byte_in;
      fill_nxt = fill_r + FILL_W'(1);
    end
    entry.full = fill_nxt[DLY_IDX_W];
    entry.crc  = {dly_nxt[3], dly_nxt[2], dly_nxt[1], dly_nxt[0]};
    entry.size = {dly_nxt[7], dly_nxt[6], dly_nxt[5], dly_nxt[4]};
    // member done, start filling again
    if (is_last) begin
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dly_r <= dly_nxt;
    end
  end

endmodule

FILE: hw/rtl/gfp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfp_queue
// Short queue between delay line and header parser.
// ----------------------------------------------------------------------------
module gfp_queue
  import gfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  gfp_entry_t push_entry,
  input  logic       pop,
  output logic       full,
  output logic       not_empty,
  output gfp_entry_t head
);

  gfp_entry_t        q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r;
  logic [QPTR_W-1:0] rd_r;
  logic [QPTR_W:0]   count_r;
  logic [QPTR_W:0]   count_nxt;

  assign full      = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = q_r[rd_r];

  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + (QPTR_W + 1)'(1);
      2'b01:   count_nxt = count_r - (QPTR_W + 1)'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_r <= QPTR_W'(wr_r + 1'b1);
      end
      if (pop) begin
        rd_r <= QPTR_W'(rd_r + 1'b1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= push_entry;
    end
  end

endmodule

FILE: hw/rtl/gfp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfp_back
// Header parser and result register: walks the gzip header fields and
// builds the framing result when the final word comes through.
// ----------------------------------------------------------------------------
module gfp_back
  import gfp_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  gfp_entry_t  head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_frame_ok,
  output logic [23:0] out_payload_offset,
  output logic [23:0] out_payload_length,
  output logic [31:0] out_trailer_crc,
  output logic [31:0] out_trailer_size
);

  phase_t                ph_r, ph_nxt, ph_p;
  logic [COUNT_BITS-1:0] pos_r, pos_nxt, pos_p, pos_inc;
  logic [7:0]            flg_r, flg_nxt, flg_p;
  logic [15:0]           skip_r, skip_nxt, skip_p, skip_dec;
  logic [COUNT_BITS-1:0] pstart_r, pstart_nxt, pstart_p;
  logic                  err_r, err_nxt, err_p;

  logic                  ovld_r, ovld_nxt;
  logic                  ok_r, ok_nxt;
  logic [23:0]           off_r, off_nxt, len_r, len_nxt;
  logic [31:0]           crc_r, crc_nxt, size_r, size_nxt;

  logic                  out_free;
  logic                  take_res;
  phase_t                nf;
  logic [2:0]            nf_stage;
  logic                  nf_go;
  logic [7:0]            b;

  assign out_free = !ovld_r || !out_stall;
  assign pop      = q_valid && (!head.last || out_free);
  assign take_res = pop && head.last;
  assign b        = head.pbyte;
  assign pos_inc  = pos_r + COUNT_BITS'(1);
  assign skip_dec = skip_r - 16'd1;

  // parse one byte
  always_comb begin
    ph_p     = ph_r;
    pos_p    = pos_r;
    flg_p    = flg_r;
    skip_p   = skip_r;
    pstart_p = pstart_r;
    err_p    = err_r;
    nf_stage = STG_EXTRA;
    nf_go    = 1'b0;
    nf       = PH_PAYLOAD;
    if (pop && head.has_byte && !err_r) begin
      if (pos_r == '1) begin
        err_p = 1'b1;
      end else begin
        pos_p = pos_inc;
        unique case (ph_r)
          PH_MAGIC0: begin
            if (b != MAGIC0) err_p = 1'b1;
            ph_p = PH_MAGIC1;
          end
          PH_MAGIC1: begin
            if (b != MAGIC1) err_p = 1'b1;
            ph_p = PH_METHOD;
          end
          PH_METHOD: begin
            if (b != CM_DEFLATE) err_p = 1'b1;
            ph_p = PH_FLAGS;
          end
          PH_FLAGS: begin
            if ((b & FLG_RESERVED) != 8'h00) err_p = 1'b1;
            flg_p  = b;
            skip_p = FIXED_SKIP;
            ph_p   = PH_FIXED;
          end
          PH_FIXED: begin
            skip_p   = skip_dec;
            nf_stage = STG_EXTRA;
            nf_go    = (skip_dec == 16'd0);
          end
          PH_XLEN0: begin
            skip_p = {8'h00, b};
            ph_p   = PH_XLEN1;
          end
          PH_XLEN1: begin
            skip_p   = skip_r | {b, 8'h00};
            nf_stage = STG_NAME;
            nf_go    = ((skip_r | {b, 8'h00}) == 16'd0);
            if (!nf_go) ph_p = PH_XDATA;
          end
          PH_XDATA: begin
            skip_p   = skip_dec;
            nf_stage = STG_NAME;
            nf_go    = (skip_dec == 16'd0);
          end
          PH_NAME: begin
            nf_stage = STG_COMMENT;
            nf_go    = (b == 8'h00);
          end
          PH_COMMENT: begin
            nf_stage = STG_HCRC;
            nf_go    = (b == 8'h00);
          end
          PH_HCRC: begin
            skip_p   = skip_dec;
            nf_stage = STG_PAYLOAD;
            nf_go    = (skip_dec == 16'd0);
          end
          PH_PAYLOAD: begin
          end
          default: begin
            err_p = 1'b1;
          end
        endcase
        nf = next_field(nf_stage, flg_r);
        if (nf_go) begin
          ph_p = nf;
          if (nf == PH_HCRC) skip_p = HCRC_LEN;
          if (nf == PH_PAYLOAD) pstart_p = pos_inc;
        end
      end
    end
  end

  // result on the final word, then back to reset values
  always_comb begin
    ph_nxt     = ph_p;
    pos_nxt    = pos_p;
    flg_nxt    = flg_p;
    skip_nxt   = skip_p;
    pstart_nxt = pstart_p;
    err_nxt    = err_p;
    ovld_nxt   = ovld_r && out_stall;
    ok_nxt     = ok_r;
    off_nxt    = off_r;
    len_nxt    = len_r;
    crc_nxt    = crc_r;
    size_nxt   = size_r;
    if (take_res) begin
      ovld_nxt = 1'b1;
      ok_nxt   = head.full && !err_p && (ph_p == PH_PAYLOAD) && (pos_p > pstart_p);
      if (ok_nxt) begin
        off_nxt  = OUT_CNT_W'(pstart_p);
        len_nxt  = OUT_CNT_W'(pos_p - pstart_p);
        crc_nxt  = head.crc;
        size_nxt = head.size;
      end else begin
        off_nxt  = '0;
        len_nxt  = '0;
        crc_nxt  = '0;
        size_nxt = '0;
      end
      ph_nxt     = PH_MAGIC0;
      pos_nxt    = '0;
      flg_nxt    = '0;
      skip_nxt   = '0;
      pstart_nxt = '0;
      err_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r     <= PH_MAGIC0;
      pos_r    <= '0;
      flg_r    <= '0;
      skip_r   <= '0;
      pstart_r <= '0;
      err_r    <= 1'b0;
      ovld_r   <= 1'b0;
    end else begin
      ph_r     <= ph_nxt;
      pos_r    <= pos_nxt;
      flg_r    <= flg_nxt;
      skip_r   <= skip_nxt;
      pstart_r <= pstart_nxt;
      err_r    <= err_nxt;
      ovld_r   <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r   <= ok_nxt;
    off_r  <= off_nxt;
    len_r  <= len_nxt;
    crc_r  <= crc_nxt;
    size_r <= size_nxt;
  end

  assign out_valid          = ovld_r;
  assign out_frame_ok       = ok_r;
  assign out_payload_offset = off_r;
  assign out_payload_length = len_r;
  assign out_trailer_crc    = crc_r;
  assign out_trailer_size   = size_r;

endmodule

FILE: hw/rtl/gzip_frame_parser_top.sv
`timescale 1ns / 1ps
// result: the final byte is written into the queue, then the parser pops it into
//   the result register, when the queue holds nothing older
// throughput: one byte per cycle while in_stall is low; the 8-byte delay line
//   and the parser each take a byte, a two-word queue sits between them
// a final byte waits in the queue only while the previous result is stalled
// reset: synchronous active-low, clears delay fill, parser, queue and result
//   valid at once; no clearing pass
// ----------------------------------------------------------------------------
// gzip_frame_parser_top
// gzip member header and trailer framing parser, one byte per word.
// ----------------------------------------------------------------------------
module gzip_frame_parser_top
  import gfp_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_in,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_frame_ok,
  output logic [23:0] out_payload_offset,
  output logic [23:0] out_payload_length,
  output logic [31:0] out_trailer_crc,
  output logic [31:0] out_trailer_size
);

  gfp_entry_t fr_entry;
  gfp_entry_t q_head;
  logic       q_full;
  logic       q_not_empty;
  logic       q_pop;
  logic       in_accept;

  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  gfp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .byte_in (in_byte_in),
    .is_last (in_is_last),
    .entry   (fr_entry)
  );

  gfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_accept),
    .push_entry (fr_entry),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  gfp_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_not_empty),
    .head               (q_head),
    .pop                (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_ok       (out_frame_ok),
    .out_payload_offset (out_payload_offset),
    .out_payload_length (out_payload_length),
    .out_trailer_crc    (out_trailer_crc),
    .out_trailer_size   (out_trailer_size)
  );

endmodule

FILE: hw/rtl/gfp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfp_checker
// Port-level checks for the gzip framing parser, bound to the top level.
// ----------------------------------------------------------------------------
module gfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_frame_ok,
  input logic [23:0] out_payload_offset,
  input logic [23:0] out_payload_length,
  input logic [31:0] out_trailer_crc,
  input logic [31:0] out_trailer_size
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_ok) &&
    $stable(out_payload_offset) && $stable(out_payload_length) &&
    $stable(out_trailer_crc) && $stable(out_trailer_size))
    else $error("result changed while stalled");

  // bad framing reports all-zero fields
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_ok |-> out_payload_offset == 24'd0 &&
    out_payload_length == 24'd0 && out_trailer_crc == 32'd0 &&
    out_trailer_size == 32'd0)
    else $error("invalid frame with non-zero fields");

  // a good frame always carries payload bytes
  a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_ok |-> out_payload_length != 24'd0)
    else $error("good frame with empty payload");

  // reset empties the result register and the queue
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset did not clear valid or stall");

endmodule

bind gzip_frame_parser_top gfp_checker u_gfp_checker (.*);
